// ----- hw/rtl/lcf_pkg.sv -----
package lcf_pkg;

   // Kernel length the storage is built for, and the widest tap count that a
   // configuration write takes effect up to.
   localparam int TAPS      = 16;
   localparam int MAX_TAPS  = 16;
   localparam int LANES     = (TAPS < MAX_TAPS) ? TAPS : MAX_TAPS;
   localparam int KIDX_W    = $clog2(LANES);
   localparam int GROUPS    = (LANES + 3) / 4;

   localparam int TAP_W     = 5;
   localparam int IDX_W     = 4;
   localparam int SAMPLE_W  = 16;
   localparam int PROD_W    = 32;
   localparam int GROUP_W   = 34;
   localparam int RESULT_W  = 36;

   localparam int QDEPTH    = 4;
   localparam int QPTR_W    = $clog2(QDEPTH);
   localparam int QCNT_W    = $clog2(QDEPTH + 1);

   localparam logic       CMD_LOAD   = 1'b0;
   localparam logic       CMD_SAMPLE = 1'b1;
   localparam logic [TAP_W-1:0] TAP_COUNT_RESET = TAP_W'(MAX_TAPS);

   // One unit of work for the back end: a kernel write or one shift of the
   // delay line with its sum of products.
   typedef struct packed {
      logic                       is_load;
      logic [IDX_W-1:0]           index;
      logic signed [SAMPLE_W-1:0] value;
      logic                       last;
   } op_type;

   // Tap count in use: at least one, at most the number of lanes built.
   function automatic logic [TAP_W-1:0] eff_taps(input logic [TAP_W-1:0] tap_count);
      logic [TAP_W-1:0] t;
      t = tap_count;
      if (t == '0) begin
         t = TAP_W'(1);
      end
      if (t > TAP_W'(LANES)) begin
         t = TAP_W'(LANES);
      end
      return t;
   endfunction

endpackage

// ----- hw/rtl/lcf_queue.sv -----
module lcf_queue
   import lcf_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   output logic   full,
   input  logic   pop,
   output op_type head_op,
   output logic   empty
);

   op_type            mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full    = (count_ff == QCNT_W'(QDEPTH));
   assign empty   = (count_ff == '0);
   assign head_op = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue read while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("queue count beyond depth");
`endif

endmodule

// ----- hw/rtl/lcf_front.sv -----
module lcf_front
   import lcf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic [TAP_W-1:0]           tap_count,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_cmd,
   input  logic [IDX_W-1:0]           req_coef_index,
   input  logic signed [SAMPLE_W-1:0] req_value,
   input  logic                       req_last_sample,
   output logic                       push,
   output op_type                     push_op,
   input  logic                       full
);

   logic [TAP_W-1:0] flush_cnt_ff, flush_cnt_in;
   logic [TAP_W-1:0] taps;
   logic             flushing;
   logic             accept;

   assign taps      = eff_taps(tap_count);
   assign flushing  = (flush_cnt_ff != '0);
   assign req_stall = full || flushing;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      flush_cnt_in    = flush_cnt_ff;
      push            = 1'b0;
      push_op.is_load = (req_cmd == CMD_LOAD);
      push_op.index   = req_coef_index;
      push_op.value   = req_value;
      push_op.last    = (req_cmd == CMD_SAMPLE) && req_last_sample && (taps == TAP_W'(1));
      if (flushing) begin
         // tail: feed zeros, mark the final one
         push_op.is_load = 1'b0;
         push_op.value   = '0;
         push_op.last    = (flush_cnt_ff == TAP_W'(1));
         if (!full) begin
            push         = 1'b1;
            flush_cnt_in = flush_cnt_ff - TAP_W'(1);
         end
      end else if (accept) begin
         push = 1'b1;
         if ((req_cmd == CMD_SAMPLE) && req_last_sample) begin
            flush_cnt_in = taps - TAP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flush_cnt_ff <= '0;
      end else begin
         flush_cnt_ff <= flush_cnt_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_flush_bounded: assert property (@(posedge clock) disable iff (reset)
      flush_cnt_ff < TAP_W'(LANES))
      else $error("tail counter out of range");
`endif

endmodule

// ----- hw/rtl/lcf_back.sv -----
module lcf_back
   import lcf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic [TAP_W-1:0]           tap_count,
   input  op_type                     head_op,
   input  logic                       empty,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [RESULT_W-1:0] rsp_result,
   output logic                       rsp_result_last
);

   logic signed [SAMPLE_W-1:0] kernel_ff [LANES];
   logic signed [SAMPLE_W-1:0] delay_ff  [LANES];
   logic signed [SAMPLE_W-1:0] delay_in  [LANES];

   logic signed [PROD_W-1:0]   prod_ff   [LANES];
   logic signed [PROD_W-1:0]   prod_in   [LANES];
   logic signed [GROUP_W-1:0]  group_ff  [GROUPS];
   logic signed [GROUP_W-1:0]  group_in  [GROUPS];
   logic signed [RESULT_W-1:0] sum_in;

   logic s1_valid_ff, s1_last_ff;
   logic s2_valid_ff, s2_last_ff;
   logic rsp_valid_ff;
   logic rsp_last_ff;
   logic signed [RESULT_W-1:0] rsp_result_ff;

   logic [TAP_W-1:0] taps;
   logic             advance;
   logic             shift;
   logic             load_ok;

   assign taps    = eff_taps(tap_count);
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign pop     = advance && !empty;
   assign shift   = pop && !head_op.is_load;
   assign load_ok = (32'(head_op.index) < LANES);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result      = rsp_result_ff;
   assign rsp_result_last = rsp_last_ff;

   // Delay line after this shift; lanes past the tap count drop out of the sum.
   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         if (j == 0) begin
            delay_in[j] = head_op.value;
         end else begin
            delay_in[j] = delay_ff[j-1];
         end
         if (j < int'(taps)) begin
            prod_in[j] = delay_in[j] * kernel_ff[j];
         end else begin
            prod_in[j] = '0;
         end
      end
   end

   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         group_in[g] = '0;
      end
      for (int j = 0; j < LANES; j++) begin
         group_in[j >> 2] = group_in[j >> 2]
                          + {{(GROUP_W-PROD_W){prod_ff[j][PROD_W-1]}}, prod_ff[j]};
      end
      sum_in = '0;
      for (int g = 0; g < GROUPS; g++) begin
         sum_in = sum_in + {{(RESULT_W-GROUP_W){group_ff[g][GROUP_W-1]}}, group_ff[g]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < LANES; j++) begin
            kernel_ff[j] <= '0;
            delay_ff[j]  <= '0;
         end
      end else begin
         if (pop && head_op.is_load && load_ok) begin
            kernel_ff[head_op.index[KIDX_W-1:0]] <= head_op.value;
         end
         if (shift) begin
            for (int j = 0; j < LANES; j++) begin
               // end of signal: clear the line for the next one
               delay_ff[j] <= head_op.last ? '0 : delay_in[j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= shift;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_last_ff    <= head_op.last;
         s2_last_ff    <= s1_last_ff;
         rsp_last_ff   <= s2_last_ff;
         prod_ff       <= prod_in;
         group_ff      <= group_in;
         rsp_result_ff <= sum_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_hold_pipe: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(s1_valid_ff) && $stable(s2_valid_ff))
      else $error("pipeline moved while output held");
   a_no_pop_on_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !pop)
      else $error("queue drained while output held");
`endif

endmodule

// ----- hw/rtl/linear_convolution_fir.sv -----
// Channel   Dir  Handshake            Beat contents
// req_      in   req_valid/req_stall  cmd, coef_index, value, last_sample
// rsp_      out  rsp_valid/rsp_stall  result (Q6.30), result_last
// csr_      in   csr_valid/csr_ready  tap_count
//
// One item per cycle is taken while the queue has room; a sample marked last
// holds the input while its tail zeros, one fewer than the tap count in use,
// go in, and longer if the queue fills.
// After its step leaves the queue head, a result is registered in turn as
// product lanes, four-term group sums and final sum.
// A held result freezes the whole back-end pipeline; the four-entry queue
// absorbs the front until it fills. Reset is synchronous and clears kernel,
// delay line and tap_count (to 16) at once, with no clearing pass.
module linear_convolution_fir
   import lcf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_cmd,
   input  logic [IDX_W-1:0]           req_coef_index,
   input  logic signed [SAMPLE_W-1:0] req_value,
   input  logic                       req_last_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [RESULT_W-1:0] rsp_result,
   output logic                       rsp_result_last,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [TAP_W-1:0]           csr_tap_count
);

   logic [TAP_W-1:0] tap_count_ff;
   logic             push;
   op_type           push_op;
   logic             full;
   logic             pop;
   op_type           head_op;
   logic             empty;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TAP_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         tap_count_ff <= csr_tap_count;
      end
   end

   lcf_front u_front (
      .clock           (clock),
      .reset           (reset),
      .tap_count       (tap_count_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_coef_index  (req_coef_index),
      .req_value       (req_value),
      .req_last_sample (req_last_sample),
      .push            (push),
      .push_op         (push_op),
      .full            (full)
   );

   lcf_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .full    (full),
      .pop     (pop),
      .head_op (head_op),
      .empty   (empty)
   );

   lcf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .tap_count       (tap_count_ff),
      .head_op         (head_op),
      .empty           (empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result      (rsp_result),
      .rsp_result_last (rsp_result_last)
   );

endmodule

// ----- tb/linear_convolution_fir_tb.sv -----
`timescale 1ns / 1ps

module linear_convolution_fir_tb
   import lcf_pkg::*;
;

   class conv_scoreboard;
      typedef struct {
         logic signed [RESULT_W-1:0] result;
         logic                       last;
      } conv_output_type;

      logic signed [SAMPLE_W-1:0] history[TAPS];
      logic signed [SAMPLE_W-1:0] kernel[TAPS];
      logic [TAP_W-1:0]           tap_reg;
      conv_output_type            pending_outputs[$];
      int                         mismatches;
      int                         n_loads;
      int                         n_samples;
      int                         n_outputs;
      int                         n_ends;

      function new();
         foreach (history[j]) begin
            history[j] = '0;
            kernel[j]  = '0;
         end
         tap_reg    = TAP_COUNT_RESET;
         mismatches = 0;
         n_loads    = 0;
         n_samples  = 0;
         n_outputs  = 0;
         n_ends     = 0;
      endfunction

      function void set_taps(logic [TAP_W-1:0] t);
         tap_reg = t;
      endfunction

      function int active_taps();
         int t;
         t = tap_reg;
         if (t < 1) begin
            t = 1;
         end
         if (t > TAPS) begin
            t = TAPS;
         end
         return t;
      endfunction

      function void shift_sample(logic signed [SAMPLE_W-1:0] x);
         for (int j = TAPS - 1; j > 0; j--) begin
            history[j] = history[j-1];
         end
         history[0] = x;
      endfunction

      function logic signed [RESULT_W-1:0] tap_sum(int n);
         logic signed [RESULT_W-1:0] acc;
         acc = '0;
         for (int j = 0; j < n; j++) begin
            acc = acc + RESULT_W'(history[j] * kernel[j]);
         end
         return acc;
      endfunction

      function void push_output(logic signed [RESULT_W-1:0] r, logic l);
         conv_output_type o;
         o.result = r;
         o.last   = l;
         pending_outputs.push_back(o);
      endfunction

      function void take_request(logic cmd, logic [IDX_W-1:0] idx,
                                 logic signed [SAMPLE_W-1:0] val, logic last);
         int n;
         n = active_taps();
         if (cmd == CMD_LOAD) begin
            n_loads++;
            if (idx < TAPS) begin
               kernel[idx] = val;
            end
            return;
         end
         n_samples++;
         shift_sample(val);
         push_output(tap_sum(n), last && (n == 1));
         if (last) begin
            n_ends++;
            // flush the tail with zeros, then start the next signal clean
            for (int k = 1; k < n; k++) begin
               shift_sample('0);
               push_output(tap_sum(n), k == n - 1);
            end
            foreach (history[j]) begin
               history[j] = '0;
            end
         end
      endfunction

      function void match_output(logic signed [RESULT_W-1:0] r, logic l);
         conv_output_type o;
         if (pending_outputs.size() == 0) begin
            $error("unexpected output beat: result %0d, result_last %0b", r, l);
            mismatches++;
            return;
         end
         o = pending_outputs.pop_front();
         n_outputs++;
         if (r !== o.result) begin
            $error("result: expected %0d, actual %0d", o.result, r);
            mismatches++;
         end
         if (l !== o.last) begin
            $error("result_last: expected %0b, actual %0b", o.last, l);
            mismatches++;
         end
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic                       req_cmd;
   logic [IDX_W-1:0]           req_coef_index;
   logic signed [SAMPLE_W-1:0] req_value;
   logic                       req_last_sample;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [RESULT_W-1:0] rsp_result;
   logic                       rsp_result_last;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [TAP_W-1:0]           csr_tap_count;

   conv_scoreboard sb = new();
   bit             quiet;
   int             n_settings;

   linear_convolution_fir u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_coef_index  (req_coef_index),
      .req_value       (req_value),
      .req_last_sample (req_last_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result      (rsp_result),
      .rsp_result_last (rsp_result_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_tap_count   (csr_tap_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.match_output(rsp_result, rsp_result_last);
      end
   end

   // output back-pressure: quiet stretches, short stalls, now and then a long one
   initial begin
      int unsigned r;
      forever begin
         r = $urandom_range(0, 99);
         if (r < 20) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(40, 120)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_stall <= 1'b1;
            repeat (r < 90 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clock);
         end
      end
   end

   initial begin
      #2ms;
      $display("linear_convolution_fir verification failed");
      $finish;
   end

   function automatic int pick_gap();
      int unsigned r;
      if (quiet) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] any_value();
      case ($urandom_range(0, 19))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'sh0000;
         3: return 16'shffff;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   task automatic send_req(logic cmd, logic [IDX_W-1:0] idx,
                           logic signed [SAMPLE_W-1:0] val, logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_cmd         <= cmd;
      req_coef_index  <= idx;
      req_value       <= val;
      req_last_sample <= last;
      req_valid       <= 1'b1;
      // hold the beat until it is taken
      do @(posedge clock); while (req_stall);
      sb.take_request(cmd, idx, val, last);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending_outputs.size() != 0) @(posedge clock);
      // loads give no output and may still be in the queue
      repeat (16) @(posedge clock);
   endtask

   task automatic write_taps(logic [TAP_W-1:0] t);
      csr_tap_count <= t;
      csr_valid     <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_taps(t);
      n_settings++;
   endtask

   task automatic run_phase(logic [TAP_W-1:0] t, int budget);
      int used;
      int len;
      wait_idle();
      write_taps(t);
      quiet = ($urandom_range(0, 3) == 0);
      used  = 0;
      for (int k = 0; k < sb.active_taps(); k++) begin
         if ($urandom_range(0, 4) != 0) begin
            send_req(CMD_LOAD, IDX_W'(k), any_value(), 1'($urandom));
            used++;
         end
      end
      while (used < budget) begin
         len = $urandom_range(1, 10);
         for (int i = 0; i < len && used < budget; i++) begin
            if ($urandom_range(0, 11) == 0) begin
               send_req(CMD_LOAD, IDX_W'($urandom), any_value(), 1'($urandom));
               used++;
            end
            // the odd signal runs on without its end mark
            send_req(CMD_SAMPLE, IDX_W'($urandom), any_value(),
                     (i == len - 1) && ($urandom_range(0, 19) != 0));
            used++;
         end
      end
   endtask

   initial begin
      logic [TAP_W-1:0] settings[9];
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_cmd         <= CMD_LOAD;
      req_coef_index  <= '0;
      req_value       <= '0;
      req_last_sample <= 1'b0;
      csr_valid       <= 1'b0;
      csr_tap_count   <= '0;
      n_settings      = 1;
      quiet           = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full kernel length out of reset; the end mark on a load does nothing
      send_req(CMD_LOAD, 4'd0, 16'sh7fff, 1'b1);
      send_req(CMD_LOAD, 4'd15, 16'sh8000, 1'b0);
      send_req(CMD_LOAD, 4'd5, 16'shffff, 1'b0);
      send_req(CMD_LOAD, 4'd10, 16'sh0001, 1'b1);
      send_req(CMD_SAMPLE, 4'd15, 16'sh7fff, 1'b0);
      send_req(CMD_SAMPLE, 4'd0, 16'sh8000, 1'b0);
      send_req(CMD_SAMPLE, 4'd7, 16'sh0000, 1'b0);
      send_req(CMD_SAMPLE, 4'd3, 16'shffff, 1'b1);
      // one tap: the sample's own output carries the end mark
      wait_idle();
      write_taps(5'd1);
      send_req(CMD_SAMPLE, 4'd0, 16'sh3039, 1'b1);
      send_req(CMD_SAMPLE, 4'd0, 16'sh8000, 1'b1);
      // zero tap count behaves as one tap
      wait_idle();
      write_taps(5'd0);
      send_req(CMD_SAMPLE, 4'd0, 16'sh8000, 1'b1);
      // oversized tap count clamps to the full store
      wait_idle();
      write_taps(5'd31);
      send_req(CMD_LOAD, 4'd15, 16'sh7fff, 1'b0);
      send_req(CMD_SAMPLE, 4'd0, 16'sh8000, 1'b0);
      send_req(CMD_SAMPLE, 4'd0, 16'sh7fff, 1'b1);

      settings = '{5'd1, 5'd0, 5'd31, 5'd2, 5'd7, 5'd16, 5'd17,
                   TAP_W'($urandom_range(2, 15)), TAP_W'($urandom_range(0, 31))};
      foreach (settings[p]) begin
         run_phase(settings[p], 27);
      end

      wait_idle();
      $display("%0d samples and %0d kernel loads over %0d tap settings",
               sb.n_samples, sb.n_loads, n_settings);
      $display("%0d outputs checked, %0d signal ends with tail flush",
               sb.n_outputs, sb.n_ends);
      if (sb.mismatches == 0 && sb.pending_outputs.size() == 0) begin
         $display("linear_convolution_fir verification clean");
      end else begin
         $display("linear_convolution_fir verification failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/lcf_pkg.sv
hw/rtl/lcf_queue.sv
hw/rtl/lcf_front.sv
hw/rtl/lcf_back.sv
hw/rtl/linear_convolution_fir.sv
tb/linear_convolution_fir_tb.sv
